// ===== hw/rtl/uets_pkg.sv =====
`timescale 1ns / 1ps
package uets_pkg;

    typedef enum logic [3:0] {
        K_BEGIN   = 4'd0,
        K_WRITE   = 4'd1,
        K_READ    = 4'd2,
        K_DONE    = 4'd3,
        K_SETUP   = 4'd4,
        K_SOF     = 4'd5,
        K_RESET   = 4'd6,
        K_UNPLUG  = 4'd7,
        K_SUSPEND = 4'd8,
        K_RESUME  = 4'd9
    } kind_t;

    // classified operations handed from front to back
    typedef enum logic [2:0] {
        OP_REQ_IN  = 3'd0,
        OP_REQ_OUT = 3'd1,
        OP_DONE_IN = 3'd2,
        OP_DONE_OUT= 3'd3,
        OP_SIMPLE  = 3'd4
    } op_t;

    localparam logic [16:0] LIM17 = 17'h1FFFF;

    typedef struct packed {
        op_t          op;
        logic [3:0]   num;
        logic [15:0]  bytes;   // request length or completion count
        kind_t        kind;    // for simple results
        logic [63:0]  setup;
        logic [10:0]  frame;
    } cmd_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   ep;
        logic         buf_sel;
        logic         first;
        logic [15:0]  off;
        logic [15:0]  cnt;
        logic [63:0]  setup;
        logic [10:0]  frame;
    } res_t;

    function automatic logic [15:0] clamp16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [16:0] sat17(input logic [17:0] v);
        return v[17] ? LIM17 : v[16:0];
    endfunction

endpackage

// ===== hw/rtl/uets_front.sv =====
`timescale 1ns / 1ps
module uets_front #(
    parameter int ENDPOINTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 func,
    input  logic [7:0]           endpoint_address,
    input  logic [15:0]          transfer_bytes,
    input  logic [31:0]          event_word,
    output logic                 push,
    output uets_pkg::cmd_t       cmd
);
    import uets_pkg::*;

    logic        pend_reg, pend_next;
    logic [29:0] half_reg, half_next;
    logic        push_reg, push_next;
    cmd_t        cmd_reg, cmd_next;
    logic [30:0] ev;
    logic [7:0]  rt;

    assign ev = event_word[30:0];
    assign rt = {half_reg[29], ev[30:24]};

    // decode one beat into a command
    always_comb
    begin
        pend_next = pend_reg;
        half_next = half_reg;
        push_next = 1'b0;
        cmd_next  = '0;
        if (take)
        begin
            if (!func)
            begin
                cmd_next.op    = endpoint_address[7] ? OP_REQ_IN : OP_REQ_OUT;
                cmd_next.num   = endpoint_address[3:0];
                cmd_next.bytes = transfer_bytes;
                push_next      = 32'(endpoint_address[3:0]) < ENDPOINTS;
            end
            else if (pend_reg)
            begin
                pend_next      = 1'b0;
                cmd_next.op    = OP_SIMPLE;
                cmd_next.kind  = K_SETUP;
                cmd_next.setup = {3'b0, half_reg[28:0], ev[15:0], ev[23:16], rt};
                push_next      = 1'b1;
            end
            else if (ev == '0)
            begin
                push_next = 1'b0;
            end
            else if (ev[30])
            begin
                pend_next = 1'b1;
                half_next = ev[29:0];
            end
            else if (ev[29:28] == 2'd2)
            begin
                cmd_next.op    = OP_SIMPLE;
                cmd_next.kind  = K_SOF;
                cmd_next.frame = ev[10:0];
                push_next      = 1'b1;
            end
            else if (ev[29:28] == 2'd3)
            begin
                cmd_next.op    = ev[7] ? OP_DONE_IN : OP_DONE_OUT;
                cmd_next.num   = ev[3:0];
                cmd_next.bytes = {3'b0, ev[20:8]};
                push_next      = 32'(ev[3:0]) < ENDPOINTS;
            end
            else if (ev >= 31'd1 && ev <= 31'd4)
            begin
                cmd_next.op   = OP_SIMPLE;
                cmd_next.kind = kind_t'(4'd5 + ev[3:0]);
                push_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            half_reg <= '0;
            push_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            half_reg <= half_next;
            push_reg <= push_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign push = push_reg;
    assign cmd  = cmd_reg;
endmodule

// ===== hw/rtl/uets_queue.sv =====
`timescale 1ns / 1ps
module uets_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  uets_pkg::cmd_t       din,
    input  logic                 pop,
    output logic                 avail,
    output logic [1:0]           fill,
    output uets_pkg::cmd_t       dout
);
    import uets_pkg::*;

    cmd_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    // two-entry fifo of classified commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= din;
    end

    assign avail = cnt_reg != 2'd0;
    assign fill  = cnt_reg;
    assign dout  = mem[rp_reg];
endmodule

// ===== hw/rtl/uets_back.sv =====
`timescale 1ns / 1ps
module uets_back #(
    parameter int ENDPOINTS   = 16,
    parameter int BLOCK_BYTES = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 avail,
    input  uets_pkg::cmd_t       cmd,
    output logic                 pop,
    output logic                 strobe,
    output uets_pkg::res_t       res,
    output logic                 last
);
    import uets_pkg::*;

    localparam int IW = $clog2(2 * ENDPOINTS) > 0 ? $clog2(2 * ENDPOINTS) : 1;
    localparam int NW = $clog2(ENDPOINTS) > 0 ? $clog2(ENDPOINTS) : 1;
    localparam logic [16:0] BLK = 17'(BLOCK_BYTES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_E0   = 5'b00100,
        S_E1   = 5'b01000,
        S_E2   = 5'b10000
    } state_t;

    // endpoint state stores; remaining / received count kept per direction
    logic [15:0] len_mem [2 * ENDPOINTS];
    logic [16:0] off_mem [2 * ENDPOINTS];
    logic        buf_mem [2 * ENDPOINTS];
    logic [16:0] rem_mem [2 * ENDPOINTS];
    logic [2 * ENDPOINTS - 1:0] act_reg;

    state_t      st_reg, st_next;
    cmd_t        c_reg;
    logic [15:0] len_reg;
    logic [16:0] off_reg, rem_reg;
    logic        buf_reg, act_q_reg;
    res_t        r0_reg, r1_reg, r2_reg, ro_reg;
    logic [1:0]  n_reg;
    logic        strobe_reg, last_reg;

    logic [IW-1:0] idx;
    logic [NW-1:0] nidx;
    logic          is_in;

    assign is_in = c_reg.op == OP_REQ_IN || c_reg.op == OP_DONE_IN;
    assign nidx  = c_reg.num[NW-1:0];
    assign idx   = is_in ? IW'(32'(ENDPOINTS) + 32'(nidx)) : IW'(nidx);

    // compute results and new endpoint state
    res_t        q [3];
    logic [1:0]  nq;
    logic [15:0] w_len;
    logic [16:0] w_off, w_rem;
    logic        w_buf, w_act, wr;
    logic [16:0] a, a2, rl, tr, blen, rem2;
    logic signed [18:0] sl;
    logic [7:0]  addr;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            q[k] = '0;
        nq    = '0;
        w_len = len_reg;
        w_off = off_reg;
        w_rem = rem_reg;
        w_buf = buf_reg;
        w_act = act_q_reg;
        wr    = 1'b0;
        a = '0; a2 = '0; rl = '0; blen = '0; rem2 = '0; sl = '0;
        tr    = {1'b0, c_reg.bytes};
        addr  = {is_in, 3'b0, c_reg.num};
        unique case (c_reg.op)
            OP_REQ_IN:
            begin
                wr = 1'b1; w_act = 1'b1;
                w_len = c_reg.bytes; w_rem = tr;
                a  = tr > BLK ? BLK : tr;
                q[0] = '{K_WRITE, addr, 1'b0, 1'b1, 16'd0, a[15:0], 64'd0, 11'd0};
                nq = 2'd1;
                w_off = a;
                a2 = tr - a;
                a2 = a2 > BLK ? BLK : a2;
                if (a != 17'd0 && a2 != 17'd0)
                begin
                    q[1] = '{K_WRITE, addr, 1'b1, 1'b0, a[15:0], a2[15:0], 64'd0, 11'd0};
                    nq = 2'd2;
                    w_off = sat17(18'(a) + 18'(a2));
                    w_buf = 1'b0;
                end
                else
                    w_buf = a != 17'd0;
            end
            OP_REQ_OUT:
            begin
                wr = 1'b1; w_act = 1'b1;
                w_len = c_reg.bytes; w_off = '0; w_rem = '0; w_buf = 1'b0;
                a = tr > BLK ? BLK : tr;
                q[0] = '{K_BEGIN, addr, 1'b0, 1'b0, 16'd0, a[15:0], 64'd0, 11'd0};
                nq = 2'd1;
            end
            OP_DONE_IN:
            begin
                if (!act_q_reg)
                begin
                    q[0] = '{K_DONE, addr, 1'b0, 1'b0, 16'd0, c_reg.bytes, 64'd0, 11'd0};
                    nq = 2'd1;
                end
                else
                begin
                    wr = 1'b1;
                    rem2 = rem_reg > tr ? rem_reg - tr : 17'd0;
                    w_rem = rem2;
                    if (rem2 == 17'd0)
                    begin
                        q[0] = '{K_DONE, addr, 1'b0, 1'b0, 16'd0, len_reg, 64'd0, 11'd0};
                        nq = 2'd1;
                        w_act = 1'b0;
                    end
                    else
                    begin
                        blen = rem2 > BLK ? BLK : rem2;
                        q[0] = '{K_BEGIN, addr, ~buf_reg, 1'b0, 16'd0, blen[15:0],
                                 64'd0, 11'd0};
                        nq = 2'd1;
                        a = {1'b0, len_reg} > off_reg ? {1'b0, len_reg} - off_reg : 17'd0;
                        a = a > BLK ? BLK : a;
                        if (a != 17'd0)
                        begin
                            q[1] = '{K_WRITE, addr, buf_reg, 1'b0, clamp16(off_reg),
                                     a[15:0], 64'd0, 11'd0};
                            nq = 2'd2;
                            w_off = sat17(18'(off_reg) + 18'(a));
                            w_buf = ~buf_reg;
                        end
                    end
                end
            end
            OP_DONE_OUT:
            begin
                if (!act_q_reg)
                begin
                    q[0] = '{K_DONE, addr, 1'b0, 1'b0, 16'd0, c_reg.bytes, 64'd0, 11'd0};
                    nq = 2'd1;
                end
                else
                begin
                    wr = 1'b1;
                    w_rem = sat17(18'(rem_reg) + 18'(tr));
                    sl = 19'(len_reg) - 19'(off_reg) - 19'(BLOCK_BYTES);
                    if (sl > 19'(BLOCK_BYTES))
                        sl = 19'(BLOCK_BYTES);
                    if (tr == BLK && sl > 0)
                    begin
                        q[nq] = '{K_BEGIN, addr, ~buf_reg, 1'b0, 16'd0, sl[15:0],
                                  64'd0, 11'd0};
                        nq = nq + 2'd1;
                    end
                    rl = w_rem > off_reg ? w_rem - off_reg : 17'd0;
                    if (rl != 17'd0)
                    begin
                        rl = rl > BLK ? BLK : rl;
                        q[nq] = '{K_READ, addr, buf_reg, 1'b0, clamp16(off_reg),
                                  rl[15:0], 64'd0, 11'd0};
                        nq = nq + 2'd1;
                        w_off = sat17(18'(off_reg) + 18'(rl));
                        w_buf = ~buf_reg;
                    end
                    if (tr < BLK || sl == 0)
                    begin
                        q[nq] = '{K_DONE, addr, 1'b0, 1'b0, 16'd0, clamp16(w_off),
                                  64'd0, 11'd0};
                        nq = nq + 2'd1;
                        w_act = 1'b0;
                    end
                end
            end
            default:
            begin
                q[0] = '{c_reg.kind, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0, c_reg.setup,
                         c_reg.frame};
                nq = 2'd1;
            end
        endcase
    end

    // sequencer: load endpoint state, compute, then emit beats
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (avail) st_next = S_LOAD;
            S_LOAD: st_next = S_E0;
            S_E0:   st_next = (n_reg > 2'd1) ? S_E1 : S_IDLE;
            S_E1:   st_next = (n_reg > 2'd2) ? S_E2 : S_IDLE;
            S_E2:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    assign pop  = st_reg == S_IDLE && avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            act_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            n_reg      <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            if (st_reg == S_LOAD)
            begin
                n_reg <= nq;
                if (wr && c_reg.op != OP_SIMPLE)
                    act_reg[idx] <= w_act;
                strobe_reg <= nq != 2'd0;
                last_reg   <= nq == 2'd1;
            end
            else if (st_reg == S_E0 && n_reg > 2'd1)
            begin
                strobe_reg <= 1'b1;
                last_reg   <= n_reg == 2'd2;
            end
            else if (st_reg == S_E1 && n_reg > 2'd2)
            begin
                strobe_reg <= 1'b1;
                last_reg   <= 1'b1;
            end
        end
    end

    // payload and memory ports
    always_ff @(posedge clk)
    begin
        if (pop)
            c_reg <= cmd;
        if (st_reg == S_LOAD)
        begin
            r0_reg <= q[0];
            r1_reg <= q[1];
            r2_reg <= q[2];
            ro_reg <= q[0];
            if (wr && c_reg.op != OP_SIMPLE)
            begin
                len_mem[idx] <= w_len;
                off_mem[idx] <= w_off;
                buf_mem[idx] <= w_buf;
                rem_mem[idx] <= w_rem;
            end
        end
        else if (st_reg == S_E0)
            ro_reg <= r1_reg;
        else if (st_reg == S_E1)
            ro_reg <= r2_reg;
    end

    // registered reads of the addressed endpoint, available the cycle after pop
    logic [IW-1:0] ridx;
    logic [NW-1:0] rn;
    assign rn   = cmd.num[NW-1:0];
    assign ridx = (cmd.op == OP_REQ_IN || cmd.op == OP_DONE_IN)
                  ? IW'(32'(ENDPOINTS) + 32'(rn)) : IW'(rn);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            off_reg   <= off_mem[ridx];
            buf_reg   <= buf_mem[ridx];
            rem_reg   <= rem_mem[ridx];
            act_q_reg <= act_reg[ridx] && 32'(cmd.num) < ENDPOINTS;
        end
        if (pop)
            len_reg <= len_mem[ridx];
    end

    assign strobe = strobe_reg;
    assign res    = ro_reg;
    assign last   = last_reg;
endmodule

// ===== hw/rtl/usb_endpoint_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// with the back end idle, the first beat comes via front register, queue and load state
// each item passes idle, load, then one emit state per beat (up to 3 beats per item)
// a two-entry command queue lets the decoder take items while the back end works
// reset: asynchronous active low; clears endpoint active flags and pending setup
// the receiver cannot stall: each result beat shows for one cycle under strobe
module usb_endpoint_transfer_sequencer #(
    parameter int ENDPOINTS   = 16,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  endpoint_address,
    input  logic [15:0] transfer_bytes,
    input  logic [31:0] event_word,
    output logic        strobe,
    output logic [3:0]  kind,
    output logic [7:0]  result_endpoint,
    output logic        buffer_select,
    output logic        first_block,
    output logic [15:0] byte_offset,
    output logic [15:0] byte_count,
    output logic [63:0] setup_packet,
    output logic [10:0] frame_number,
    output logic        last
);
    import uets_pkg::*;

    logic       take, push, pop, avail;
    logic [1:0] fill;
    cmd_t       fcmd, qcmd;
    res_t       r;

    // stall the front while the queue could overflow
    assign busy = fill != 2'd0 || push;
    assign take = start && !busy;

    uets_front #(.ENDPOINTS(ENDPOINTS)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .func(func),
        .endpoint_address(endpoint_address), .transfer_bytes(transfer_bytes),
        .event_word(event_word), .push(push), .cmd(fcmd)
    );

    uets_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(fcmd), .pop(pop),
        .avail(avail), .fill(fill), .dout(qcmd)
    );

    uets_back #(.ENDPOINTS(ENDPOINTS), .BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .cmd(qcmd), .pop(pop),
        .strobe(strobe), .res(r), .last(last)
    );

    assign kind            = r.kind;
    assign result_endpoint = r.ep;
    assign buffer_select   = r.buf_sel;
    assign first_block     = r.first;
    assign byte_offset     = r.off;
    assign byte_count      = r.cnt;
    assign setup_packet    = r.setup;
    assign frame_number    = r.frame;
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import uets_pkg::*;

    localparam int EPS = 16;
    localparam int BLK = 512;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        func = 1'b0;
    logic [7:0]  endpoint_address = '0;
    logic [15:0] transfer_bytes = '0;
    logic [31:0] event_word = '0;
    logic        strobe;
    logic [3:0]  kind;
    logic [7:0]  result_endpoint;
    logic        buffer_select;
    logic        first_block;
    logic [15:0] byte_offset;
    logic [15:0] byte_count;
    logic [63:0] setup_packet;
    logic [10:0] frame_number;
    logic        last;

    typedef struct {
        kind_t       k;
        logic [7:0]  ep;
        logic        bsel;
        logic        first;
        logic [15:0] off;
        logic [15:0] cnt;
        logic [63:0] setup;
        logic [10:0] frame;
        logic        lst;
    } beat_t;

    beat_t expected_beats[$];
    int errors = 0;
    int cycles = 0;
    int burst_left = 0;

    // endpoint bookkeeping: IN at EPS+num, OUT at num
    int unsigned xfer_len [2*EPS];
    int unsigned xfer_off [2*EPS];
    int unsigned in_left  [EPS];
    int unsigned out_got  [EPS];
    bit          buf_flag [2*EPS];
    bit          ep_open  [2*EPS];
    bit          setup_wait;
    logic [29:0] setup_lo;
    int          pushed;

    usb_endpoint_transfer_sequencer DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .endpoint_address(endpoint_address), .transfer_bytes(transfer_bytes),
        .event_word(event_word), .strobe(strobe), .kind(kind),
        .result_endpoint(result_endpoint), .buffer_select(buffer_select),
        .first_block(first_block), .byte_offset(byte_offset), .byte_count(byte_count),
        .setup_packet(setup_packet), .frame_number(frame_number), .last(last)
    );

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned min_u(int unsigned a, int unsigned b);
        return a < b ? a : b;
    endfunction

    function automatic void push_beat(kind_t k, int unsigned ep, bit bsel, bit first,
                                      int unsigned off, int unsigned cnt,
                                      logic [63:0] setup, int unsigned frame);
        beat_t b;
        b.k = k;
        b.ep = ep[7:0];
        b.bsel = bsel;
        b.first = first;
        b.off = min_u(off, 16'hFFFF);
        b.cnt = min_u(cnt, 16'hFFFF);
        b.setup = setup;
        b.frame = frame[10:0];
        b.lst = 1'b0;
        expected_beats.push_back(b);
        pushed++;
    endfunction

    function automatic void in_chunk(int idx, int unsigned addr, bit opening);
        int unsigned len;
        len = xfer_len[idx] > xfer_off[idx] ? xfer_len[idx] - xfer_off[idx] : 0;
        len = min_u(len, BLK);
        if (len > 0)
        begin
            push_beat(K_WRITE, addr, buf_flag[idx], opening, xfer_off[idx], len, '0, 0);
            xfer_off[idx] = min_u(xfer_off[idx] + len, 17'h1FFFF);
            buf_flag[idx] ^= 1'b1;
        end
        else if (opening)
            push_beat(K_WRITE, addr, buf_flag[idx], 1'b1, xfer_off[idx], 0, '0, 0);
    endfunction

    function automatic void in_xfer_end(int num, int unsigned moved);
        int idx;
        int unsigned addr;
        idx = EPS + num;
        addr = 8'h80 | num;
        if (!ep_open[idx])
        begin
            push_beat(K_DONE, addr, 0, 0, 0, moved, '0, 0);
            return;
        end
        in_left[num] = in_left[num] > moved ? in_left[num] - moved : 0;
        if (in_left[num] == 0)
        begin
            push_beat(K_DONE, addr, 0, 0, 0, xfer_len[idx], '0, 0);
            ep_open[idx] = 1'b0;
            return;
        end
        push_beat(K_BEGIN, addr, ~buf_flag[idx], 0, 0, min_u(in_left[num], BLK), '0, 0);
        in_chunk(idx, addr, 1'b0);
    endfunction

    function automatic void out_xfer_end(int num, int unsigned moved);
        int len;
        int unsigned rlen;
        if (!ep_open[num])
        begin
            push_beat(K_DONE, num, 0, 0, 0, moved, '0, 0);
            return;
        end
        out_got[num] = min_u(out_got[num] + moved, 17'h1FFFF);
        len = int'(xfer_len[num]) - int'(xfer_off[num]) - BLK;
        if (len > BLK) len = BLK;
        if (moved == BLK && len > 0)
            push_beat(K_BEGIN, num, ~buf_flag[num], 0, 0, len, '0, 0);
        rlen = out_got[num] > xfer_off[num] ? out_got[num] - xfer_off[num] : 0;
        if (rlen > 0)
        begin
            rlen = min_u(rlen, BLK);
            push_beat(K_READ, num, buf_flag[num], 0, xfer_off[num], rlen, '0, 0);
            xfer_off[num] = min_u(xfer_off[num] + rlen, 17'h1FFFF);
            buf_flag[num] ^= 1'b1;
        end
        if (moved < BLK || len == 0)
        begin
            push_beat(K_DONE, num, 0, 0, 0, xfer_off[num], '0, 0);
            ep_open[num] = 1'b0;
        end
    endfunction

    function automatic void decode_event(logic [31:0] raw);
        logic [30:0] ev;
        logic [63:0] pkt;
        int num;
        ev = raw[30:0];
        if (setup_wait)
        begin
            setup_wait = 1'b0;
            pkt = '0;
            pkt[7:0] = {setup_lo[29], ev[30:24]};
            pkt[15:8] = ev[23:16];
            pkt[31:16] = ev[15:0];
            pkt[47:32] = setup_lo[15:0];
            pkt[60:48] = setup_lo[28:16];
            push_beat(K_SETUP, 0, 0, 0, 0, 0, pkt, 0);
            return;
        end
        if (ev == 0) return;
        if (ev[30])
        begin
            setup_wait = 1'b1;
            setup_lo = ev[29:0];
        end
        else if (ev[30:28] == 3'd2)
            push_beat(K_SOF, 0, 0, 0, 0, 0, '0, ev[10:0]);
        else if (ev[30:28] == 3'd3)
        begin
            num = ev[3:0];
            if (ev[7]) in_xfer_end(num, ev[20:8]);
            else out_xfer_end(num, ev[20:8]);
        end
        else if (ev >= 1 && ev <= 4)
            push_beat(kind_t'(4'd5 + ev[3:0]), 0, 0, 0, 0, 0, '0, 0);
    endfunction

    function automatic void open_transfer(logic [7:0] epa, logic [15:0] bytes);
        int num;
        int idx;
        num = epa[3:0];
        idx = epa[7] ? EPS + num : num;
        xfer_len[idx] = bytes;
        xfer_off[idx] = 0;
        buf_flag[idx] = 1'b0;
        ep_open[idx] = 1'b1;
        if (epa[7])
        begin
            in_left[num] = bytes;
            in_chunk(idx, 8'h80 | num, 1'b1);
            in_chunk(idx, 8'h80 | num, 1'b0);
        end
        else
        begin
            out_got[num] = 0;
            push_beat(K_BEGIN, num, 0, 0, 0, min_u(bytes, BLK), '0, 0);
        end
    endfunction

    // one beat into the block, with bursty gaps on the sender side
    task automatic send_item(bit f, logic [7:0] epa, logic [15:0] bytes, logic [31:0] ev);
        int gap;
        func = f;
        endpoint_address = epa;
        transfer_bytes = bytes;
        event_word = ev;
        start = 1'b1;
        // busy only moves at the rising edge, so it is stable here
        while (busy) @(negedge clk);
        @(posedge clk);
        pushed = 0;
        if (f) decode_event(ev);
        else open_transfer(epa, bytes);
        if (pushed > 0) expected_beats[expected_beats.size() - 1].lst = 1'b1;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start = 1'b0;
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic logic [31:0] done_word(logic [7:0] epa, logic [12:0] moved);
        return {1'($urandom), 3'b011, 7'd0, moved, epa};
    endfunction

    function automatic logic [7:0] rand_addr(bit dir_in);
        return {dir_in, 3'($urandom), 4'($urandom)};
    endfunction

    // result checker
    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n && strobe)
        begin
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected beat kind=%0d", kind);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (kind !== e.k || result_endpoint !== e.ep || buffer_select !== e.bsel ||
                    first_block !== e.first || byte_offset !== e.off ||
                    byte_count !== e.cnt || setup_packet !== e.setup ||
                    frame_number !== e.frame || last !== e.lst)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch exp: k=%0d ep=%h b=%b f=%b off=%0d cnt=%0d su=%h fr=%0d l=%b",
                                 e.k, e.ep, e.bsel, e.first, e.off, e.cnt, e.setup, e.frame,
                                 e.lst);
                        $display("         got: k=%0d ep=%h b=%b f=%b off=%0d cnt=%0d su=%h fr=%0d l=%b",
                                 kind, result_endpoint, buffer_select, first_block,
                                 byte_offset, byte_count, setup_packet, frame_number, last);
                    end
                end
            end
        end
    end

    // edge values, bus events, setup pairing, inactive completions
    task automatic test_directed();
        send_item(1, 0, 0, 32'h0000_0001);
        send_item(1, 0, 0, 32'h8000_0002);
        send_item(1, 0, 0, 32'h0000_0003);
        send_item(1, 0, 0, 32'h0000_0004);
        send_item(1, 0, 0, 32'h0000_0000);
        send_item(1, 0, 0, 32'h0000_0005);
        send_item(1, 0, 0, 32'h1FFF_FFFF);
        send_item(1, 0, 0, 32'hAFFF_FFFF);
        send_item(1, 0, 0, 32'h2000_0000);
        send_item(1, 0, 0, 32'h3000_3E8E);
        send_item(1, 0, 0, 32'h3000_000E);
        send_item(0, 8'h81, 16'd0, '0);
        send_item(0, 8'hFF, 16'hFFFF, '0);
        send_item(1, 0, 0, 32'h7FFF_FFFF);
        send_item(0, 8'h70, 16'd0, '0);
        send_item(1, 0, 0, 32'h0000_0000);
        send_item(1, 0, 0, 32'h4000_0000);
        send_item(1, 0, 0, 32'hFFFF_FFFF);
        send_item(1, 0, 0, done_word(8'h8F, 13'h1FFF));
        send_item(0, 8'h02, 16'd700, '0);
        send_item(1, 0, 0, done_word(8'h02, 13'd512));
        send_item(1, 0, 0, done_word(8'h02, 13'd512));
        send_item(1, 0, 0, done_word(8'h02, 13'd100));
        send_item(1, 0, 0, done_word(8'h81, 13'd0));
    endtask

    // well-formed IN transfers with random completion sizes
    task automatic test_in_transfers(int n);
        logic [7:0] epa;
        int unsigned len;
        for (int i = 0; i < n; i++)
        begin
            epa = rand_addr(1);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 2500);
            send_item(0, epa, 16'(len), '0);
            repeat ($urandom_range(1, 5))
                send_item(1, 0, 0, done_word(epa & 8'h8F,
                          13'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : BLK)));
        end
    endtask

    // well-formed OUT transfers, short packets end them
    task automatic test_out_transfers(int n);
        logic [7:0] epa;
        int unsigned len;
        for (int i = 0; i < n; i++)
        begin
            epa = rand_addr(0);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 2500);
            send_item(0, epa, 16'(len), '0);
            repeat ($urandom_range(1, 5))
                send_item(1, 0, 0, done_word(epa & 8'h0F,
                          13'($urandom_range(0, 2) == 0 ? $urandom_range(0, 8191) : BLK)));
        end
    endtask

    // setup pairs, sof and bus events, plus raw noise
    task automatic test_events(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: begin
                    send_item(1, 0, 0, {1'($urandom), 1'b1, 30'($urandom)});
                    if ($urandom_range(0, 2) == 0)
                        send_item(0, 8'($urandom), 16'($urandom), '0);
                    send_item(1, 0, 0, $urandom);
                end
                1: send_item(1, 0, 0, {1'($urandom), 3'b010, 28'($urandom)});
                2: send_item(1, 0, 0, {1'($urandom), 31'($urandom_range(0, 4))});
                3: send_item(1, 0, 0, done_word(8'($urandom), 13'($urandom)));
                4: send_item(0, 8'($urandom), 16'($urandom), '0);
                default: send_item(1, 0, 0, $urandom);
            endcase
        end
    endtask

    initial
    begin
        for (int i = 0; i < 2*EPS; i++) ep_open[i] = 1'b0;
        setup_wait = 1'b0;
        setup_lo = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_in_transfers(35);
        test_out_transfers(35);
        test_events(100);
        @(negedge clk);
        start = 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
